// File: rtl/g711_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g711_pkg: shared types and constants for the companding codec
// Transaction kind codes, field widths and the fixed companding constants.
// ----------------------------------------------------------------------------
package g711_pkg;

    localparam int PCM_W  = 16;
    localparam int CODE_W = 8;
    localparam int KIND_W = 2;
    localparam int DATA_W = PCM_W + CODE_W;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [PCM_W-1:0]  pcm_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [DATA_W-1:0] data_t;

    localparam kind_t KIND_ALAW_ENC  = 2'd0;
    localparam kind_t KIND_MULAW_ENC = 2'd1;
    localparam kind_t KIND_ALAW_DEC  = 2'd2;
    localparam kind_t KIND_MULAW_DEC = 2'd3;

    localparam code_t       ALAW_TOGGLE = 8'h55;
    localparam logic [16:0] MU_BIAS     = 17'(33 * 4);
    localparam logic [15:0] SEG_BASE    = 16'h0084;
    localparam logic [16:0] PCM_MAX     = 17'h07FFF;

endpackage

// File: rtl/g711_companding_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g711_companding_codec: A-law / mu-law encoder and decoder
// Converts 16-bit linear samples to 8-bit codes and back, one per ready cycle.
// ----------------------------------------------------------------------------
// channel   dir  tdata                                  tuser   tlast
// s_axis    in   [15:0] pcm_sample, [23:16] code_byte   kind    last_in
// m_axis    out  [15:0] pcm_result, [23:16] code_result  -       last_out
//
// one transaction per cycle sustained while m_axis_tready holds; the result
// reaches m_axis through the input register, then the result register
// the segment leading-one detect and shifts sit between the two registers
// rst_n clears the valid flags only; data registers are not reset
// with both registers full, s_axis_tready follows m_axis_tready in the same
// cycle, so in steady flow a stall stops s_axis at once; an empty input
// register still takes one transaction
// ----------------------------------------------------------------------------
module g711_companding_codec (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  g711_pkg::data_t s_axis_tdata,   // pcm_sample, code_byte
    input  g711_pkg::kind_t s_axis_tuser,   // kind
    input  logic            s_axis_tlast,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output g711_pkg::data_t m_axis_tdata,   // pcm_result, code_result
    output logic            m_axis_tlast
);
    import g711_pkg::*;

    logic  s1_valid_reg;
    kind_t s1_kind_reg;
    pcm_t  s1_pcm_reg;
    code_t s1_code_reg;
    logic  s1_last_reg;

    logic  out_valid_reg;
    pcm_t  out_pcm_reg;
    code_t out_code_reg;
    logic  out_last_reg;

    logic  s1_adv;
    logic  in_acc;
    pcm_t  pcm_next;
    code_t code_next;

    // segment of a 15-bit magnitude: leading one at bit 8..14 gives 1..7
    function automatic logic [2:0] seg_of(input logic [14:0] mag);
        logic [2:0] seg;
        seg = 3'd0;
        for (int b = 8; b <= 14; b++)
        begin
            if (mag[b])
                seg = 3'(b - 7);
        end
        return seg;
    endfunction

    function automatic code_t alaw_enc(input pcm_t raw);
        logic        neg;
        logic [14:0] mag;
        logic [2:0]  seg;
        logic [3:0]  shamt;
        logic [14:0] sh;
        neg   = raw[15];
        mag   = neg ? ~raw[14:0] : raw[14:0];
        seg   = seg_of(mag);
        shamt = (seg != 3'd0) ? ({1'b0, seg} + 4'd3) : 4'd4;
        sh    = mag >> shamt;
        return ALAW_TOGGLE ^ {neg, seg, sh[3:0]};
    endfunction

    function automatic code_t mulaw_enc(input pcm_t raw);
        logic        neg;
        logic [15:0] absval;
        logic [16:0] sum;
        logic [14:0] mag;
        logic [2:0]  seg;
        logic [14:0] sh;
        neg    = raw[15];
        absval = neg ? (16'd0 - raw) : raw;
        sum    = {1'b0, absval} + MU_BIAS;
        mag    = (sum > PCM_MAX) ? PCM_MAX[14:0] : sum[14:0];
        seg    = seg_of(mag);
        sh     = mag >> ({1'b0, seg} + 4'd3);
        return ~{neg, seg, sh[3:0]};
    endfunction

    function automatic pcm_t apply_sign(input logic neg, input pcm_t val);
        return neg ? (16'd0 - val) : val;
    endfunction

    function automatic pcm_t alaw_dec(input code_t code);
        code_t      t;
        logic [2:0] seg;
        pcm_t       val;
        t   = code ^ ALAW_TOGGLE;
        seg = t[6:4];
        if (seg != 3'd0)
            val = ({9'd0, t[3:0], 3'd0} | SEG_BASE) << seg;
        else
            val = {8'd0, t[3:0], 4'b1000};
        return apply_sign(t[7], val);
    endfunction

    function automatic pcm_t mulaw_dec(input code_t code);
        code_t      t;
        logic [2:0] seg;
        pcm_t       val;
        t   = ~code;
        seg = t[6:4];
        val = (SEG_BASE << seg) | ({12'd0, t[3:0]} << ({1'b0, seg} + 4'd3));
        val = val - MU_BIAS[15:0];
        return apply_sign(t[7], val);
    endfunction

    // pipeline handshake
    assign s1_adv        = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        pcm_next  = '0;
        code_next = '0;
        unique case (s1_kind_reg)
            KIND_ALAW_ENC:  code_next = alaw_enc(s1_pcm_reg);
            KIND_MULAW_ENC: code_next = mulaw_enc(s1_pcm_reg);
            KIND_ALAW_DEC:  pcm_next  = alaw_dec(s1_code_reg);
            KIND_MULAW_DEC: pcm_next  = mulaw_dec(s1_code_reg);
            default:        pcm_next  = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                s1_valid_reg <= s_axis_tvalid;
            if (s1_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_kind_reg <= s_axis_tuser;
            s1_pcm_reg  <= s_axis_tdata[PCM_W-1:0];
            s1_code_reg <= s_axis_tdata[DATA_W-1:PCM_W];
            s1_last_reg <= s_axis_tlast;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_pcm_reg  <= pcm_next;
            out_code_reg <= code_next;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_code_reg, out_pcm_reg};
    assign m_axis_tlast  = out_last_reg;

    // an empty input register never blocks the slave side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_axis_tready)
        else $error("s_axis_tready low with empty input register");

    // an accepted transaction lands in the input register
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> s1_valid_reg)
        else $error("accepted transaction lost");

    // encode kinds leave the linear field at zero
    a_enc_pcm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_adv &&
         (s1_kind_reg == KIND_ALAW_ENC || s1_kind_reg == KIND_MULAW_ENC))
        |=> (out_valid_reg && out_pcm_reg == '0))
        else $error("encode result carries nonzero pcm field");

    // decode kinds leave the code field at zero
    a_dec_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_adv &&
         (s1_kind_reg == KIND_ALAW_DEC || s1_kind_reg == KIND_MULAW_DEC))
        |=> (out_valid_reg && out_code_reg == '0))
        else $error("decode result carries nonzero code field");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for g711_companding_codec
// Drives A-law and mu-law encode and decode transactions with random gaps on
// both sides. Every result is checked against a local companding predictor.
// ----------------------------------------------------------------------------
module tb;

    import g711_pkg::*;

    typedef struct packed {
        pcm_t  pcm;
        code_t code;
        logic  last;
    } codec_result_t;

    class companding_checker;
        codec_result_t awaited_results[$];
        int            mismatches = 0;

        function int pending();
            return awaited_results.size();
        endfunction

        // leading one at bit 8..14 gives segment 1..7
        function logic [2:0] segment_of(logic [14:0] mag);
            for (int b = 14; b >= 8; b--)
            begin
                if (mag[b])
                    return 3'(b - 7);
            end
            return 3'd0;
        endfunction

        function code_t alaw_encode(pcm_t sample);
            logic        neg;
            logic [14:0] mag;
            logic [2:0]  seg;
            int          sh;
            logic [3:0]  nib;
            neg = sample[15];
            // negatives use the bitwise inverse, so full scale never overflows
            mag = neg ? ~sample[14:0] : sample[14:0];
            seg = segment_of(mag);
            sh  = (seg != 0) ? int'(seg) + 3 : 4;
            nib = 4'(mag >> sh);
            return ALAW_TOGGLE ^ {neg, 7'b0} ^ {1'b0, seg, 4'b0} ^ {4'b0, nib};
        endfunction

        function code_t mulaw_encode(pcm_t sample);
            int         val;
            int         mag;
            logic [2:0] seg;
            logic [3:0] nib;
            val = int'(signed'(sample));
            mag = (val < 0) ? -val : val;
            mag = mag + int'(MU_BIAS);
            if (mag > int'(PCM_MAX))
                mag = int'(PCM_MAX);
            seg = segment_of(mag[14:0]);
            nib = 4'(mag >> (int'(seg) + 3));
            return ~({val < 0, 7'b0} ^ {1'b0, seg, 4'b0} ^ {4'b0, nib});
        endfunction

        function pcm_t alaw_decode(code_t code);
            code_t      t;
            logic [2:0] seg;
            int         mag;
            t   = code ^ ALAW_TOGGLE;
            seg = t[6:4];
            if (seg != 0)
                mag = ((int'(t[3:0]) << 3) | int'(SEG_BASE)) << seg;
            else
                mag = (int'(t[3:0]) << 4) + 8;    // half-step reconstruction
            return t[7] ? pcm_t'(-mag) : pcm_t'(mag);
        endfunction

        function pcm_t mulaw_decode(code_t code);
            code_t      t;
            logic [2:0] seg;
            int         mag;
            t   = ~code;
            seg = t[6:4];
            mag = ((int'(SEG_BASE) << seg) | (int'(t[3:0]) << (int'(seg) + 3)))
                  - int'(MU_BIAS);
            return t[7] ? pcm_t'(-mag) : pcm_t'(mag);
        endfunction

        function void note_input(kind_t kind, data_t data, logic last);
            codec_result_t r;
            r.pcm  = '0;
            r.code = '0;
            r.last = last;
            case (kind)
                KIND_ALAW_ENC:  r.code = alaw_encode(data[PCM_W-1:0]);
                KIND_MULAW_ENC: r.code = mulaw_encode(data[PCM_W-1:0]);
                KIND_ALAW_DEC:  r.pcm  = alaw_decode(data[DATA_W-1:PCM_W]);
                default:        r.pcm  = mulaw_decode(data[DATA_W-1:PCM_W]);
            endcase
            awaited_results.push_back(r);
        endfunction

        function void report(string field, int unsigned exp_v, int unsigned act_v);
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, field, exp_v, act_v);
        endfunction

        function void check_result(data_t data, logic last);
            codec_result_t r;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h last %b",
                         $time, data, last);
                return;
            end
            r = awaited_results.pop_front();
            if (data[PCM_W-1:0] !== r.pcm)
                report("pcm_result", r.pcm, data[PCM_W-1:0]);
            if (data[DATA_W-1:PCM_W] !== r.code)
                report("code_result", r.code, data[DATA_W-1:PCM_W]);
            if (last !== r.last)
                report("last_out", r.last, last);
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  s_axis_tvalid = 1'b0;
    logic  s_axis_tready;
    data_t s_axis_tdata = '0;
    kind_t s_axis_tuser = KIND_ALAW_ENC;
    logic  s_axis_tlast = 1'b0;
    logic  m_axis_tvalid;
    logic  m_axis_tready = 1'b0;
    data_t m_axis_tdata;
    logic  m_axis_tlast;

    companding_checker sb;
    bit no_idle = 1'b0;
    bit sender_burst = 1'b0;
    bit long_hold_req = 1'b0;

    g711_companding_codec i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input(s_axis_tuser, s_axis_tdata, s_axis_tlast);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // result side backpressure
    initial
    begin
        int gap;
        @(negedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (200) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else
            begin
                gap = no_idle ? 0 : $urandom_range(0, 10);
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic send_item(input kind_t kind, input pcm_t sample, input code_t code,
                             input logic last);
        int gap;
        gap = (no_idle || sender_burst) ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {code, sample};
        s_axis_tuser  <= kind;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // mix of full-range samples and small magnitudes so every segment is hit
    function automatic pcm_t random_sample();
        int width;
        int mag;
        if ($urandom_range(0, 1))
            return pcm_t'($urandom);
        width = $urandom_range(0, 15);
        mag = $urandom & ((1 << width) - 1);
        return $urandom_range(0, 1) ? pcm_t'(-mag) : pcm_t'(mag);
    endfunction

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // full scale, zero, sign edges and segment boundaries
        send_item(KIND_ALAW_ENC, 16'h0000, code_t'($urandom), 1'b0);
        send_item(KIND_ALAW_ENC, 16'h7FFF, code_t'($urandom), 1'b1);
        send_item(KIND_ALAW_ENC, 16'h8000, code_t'($urandom), 1'b0);
        send_item(KIND_ALAW_ENC, 16'hFFFF, code_t'($urandom), 1'b1);
        send_item(KIND_ALAW_ENC, 16'h0001, code_t'($urandom), 1'b0);
        send_item(KIND_ALAW_ENC, 16'h00FF, code_t'($urandom), 1'b0);
        send_item(KIND_ALAW_ENC, 16'h0100, code_t'($urandom), 1'b1);
        send_item(KIND_MULAW_ENC, 16'h0000, code_t'($urandom), 1'b0);
        send_item(KIND_MULAW_ENC, 16'h7FFF, code_t'($urandom), 1'b1);
        send_item(KIND_MULAW_ENC, 16'h8000, code_t'($urandom), 1'b0);
        send_item(KIND_MULAW_ENC, 16'hFFFF, code_t'($urandom), 1'b1);
        send_item(KIND_MULAW_ENC, 16'h7F7B, code_t'($urandom), 1'b0);
        send_item(KIND_MULAW_ENC, 16'h7F7C, code_t'($urandom), 1'b0);
        send_item(KIND_ALAW_DEC, pcm_t'($urandom), 8'h00, 1'b1);
        send_item(KIND_ALAW_DEC, pcm_t'($urandom), 8'hFF, 1'b0);
        send_item(KIND_ALAW_DEC, pcm_t'($urandom), 8'h55, 1'b1);
        send_item(KIND_ALAW_DEC, pcm_t'($urandom), 8'hD5, 1'b0);
        send_item(KIND_MULAW_DEC, pcm_t'($urandom), 8'hFF, 1'b1);
        send_item(KIND_MULAW_DEC, pcm_t'($urandom), 8'h7F, 1'b0);
        send_item(KIND_MULAW_DEC, pcm_t'($urandom), 8'h00, 1'b1);
        send_item(KIND_MULAW_DEC, pcm_t'($urandom), 8'h80, 1'b0);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        for (int i = 0; i < 1700; i++)
        begin
            // long receiver stall while the sender keeps pushing
            if (i == 300)
            begin
                long_hold_req = 1'b1;
                sender_burst  = 1'b1;
            end
            if (i == 360)
                sender_burst = 1'b0;
            if (i == 800)
                no_idle = 1'b1;
            if (i == 1100)
                no_idle = 1'b0;
            if (i == 1300)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            send_item(kind_t'($urandom_range(0, 3)), random_sample(), code_t'($urandom),
                      ($urandom_range(0, 7) == 0));
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("g711_companding_codec verification clean");
        else
            $display("g711_companding_codec verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("g711_companding_codec verification failed");
        $finish;
    end

endmodule

// File: g711_companding_codec.f
rtl/g711_pkg.sv
rtl/g711_companding_codec.sv
tb/tb.sv
